// ----- rtl/cimr_pkg.sv -----
package cimr_pkg;

    // Field and register widths
    localparam int COORD_W     = 10;
    localparam int SAMPLE_W    = 16;
    localparam int SRC_IDX_W   = 5;
    localparam int SRC_REG_W   = 6;
    localparam int TGT_REG_W   = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_HEIGHT = 2'd3;

    localparam logic [SRC_REG_W-1:0] SRC_SIZE_RST = 6'd2;
    localparam logic [TGT_REG_W-1:0] TGT_SIZE_RST = 11'd1024;

    // Commands
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Parameter defaults
    localparam int SOURCE_MAX_DEF = 32;
    localparam int TARGET_MAX_DEF = 1024;

    // Cosine weight table
    localparam int WEIGHT_ENTRIES = 256;
    localparam int W_BITS         = $clog2(WEIGHT_ENTRIES);
    localparam int WQ_BITS        = 15;
    localparam int WEIGHT_W       = WQ_BITS + 1;
    localparam longint ROUND_HALF = 64'sd1 <<< (WQ_BITS - 1);

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned TAYLOR_DIV [12] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
          64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

    typedef logic [WEIGHT_W-1:0] t_wtab [WEIGHT_ENTRIES];

    typedef struct packed {
        logic busy;
        logic done;
    } t_axis_stat;

    // Taylor series of cos in Q30, each term truncated, clamped to [0, 1]
    function automatic longint cos_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        int              k;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        acc  = longint'(ONE_Q30);
        for (k = 0; k < 12; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k[0] == 1'b0) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(ONE_Q30)) begin
            acc = longint'(ONE_Q30);
        end
        return acc;
    endfunction

    // (1 - cos(pi*f/N)) / 2 in Q1.15, mirrored for the upper half
    function automatic logic [WEIGHT_W-1:0] weight_q15(input int f);
        logic            flip;
        longint unsigned j;
        longint unsigned x;
        longint          c;
        longint          h;
        flip = (2 * f) > WEIGHT_ENTRIES;
        j    = flip ? longint'(WEIGHT_ENTRIES - f) : longint'(f);
        x    = (PI_Q30 * j) / WEIGHT_ENTRIES;
        c    = cos_q30(x);
        h    = (longint'(ONE_Q30) - c + 64'sd32768) >>> 16;
        if (flip) begin
            h = 64'sd32768 - h;
        end
        return WEIGHT_W'(h);
    endfunction

    function automatic t_wtab build_wtab();
        t_wtab t;
        int    f;
        for (f = 0; f < WEIGHT_ENTRIES; f++) begin
            t[f] = weight_q15(f);
        end
        return t;
    endfunction

endpackage

// ----- rtl/cimr_axis.sv -----
module cimr_axis #(
    parameter int SOURCE_MAX = cimr_pkg::SOURCE_MAX_DEF,
    parameter int TARGET_MAX = cimr_pkg::TARGET_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [cimr_pkg::COORD_W-1:0]        i_coord,
    input  logic [$clog2(SOURCE_MAX+1)-1:0]     i_ssz,
    input  logic [$clog2(TARGET_MAX+1)-1:0]     i_tsz,
    output cimr_pkg::t_axis_stat                o_stat,
    output logic [$clog2(SOURCE_MAX)-1:0]       o_i0,
    output logic [$clog2(SOURCE_MAX)-1:0]       o_i1,
    output logic [cimr_pkg::W_BITS-1:0]         o_frac
);
    import cimr_pkg::*;

    localparam int SZW = $clog2(SOURCE_MAX + 1);
    localparam int TZW = $clog2(TARGET_MAX + 1);
    localparam int SIW = $clog2(SOURCE_MAX);
    localparam int QW  = SIW + W_BITS;
    localparam int PW  = COORD_W + SZW;
    localparam int CW  = $clog2(QW);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]         r_phase;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [COORD_W-1:0] r_coord;
    logic [SZW-1:0]     r_msh;
    logic [SZW-1:0]     r_ssz;
    logic [TZW-1:0]     r_tsz;
    logic [PW-1:0]      r_prod;
    logic [TZW-1:0]     r_rem;
    logic [QW-1:0]      r_dsh;
    logic [QW-1:0]      r_quo;
    logic [SIW-1:0]     r_i0;
    logic [SIW-1:0]     r_i1;
    logic [W_BITS-1:0]  r_frac;

    logic [PW-1:0]      n_prod;
    logic [TZW:0]       n_r2;
    logic               div_ge;
    logic [TZW-1:0]     n_rem;
    logic [QW-1:0]      n_quo;
    logic [SIW-1:0]     n_i0;
    logic [SIW:0]       n_nxt;
    logic [SIW:0]       ssz_x;
    logic [SIW-1:0]     n_i1;

    always_comb begin
        // Multiply MSB first: one bit of the size per cycle
        n_prod = {r_prod[PW-2:0], 1'b0} + (r_msh[SZW-1] ? PW'(r_coord) : PW'(0));
        // Restoring divide: one quotient bit per cycle
        n_r2   = {r_rem, r_dsh[QW-1]};
        div_ge = n_r2 >= (TZW+1)'(r_tsz);
        n_rem  = div_ge ? TZW'(n_r2 - (TZW+1)'(r_tsz)) : n_r2[TZW-1:0];
        n_quo  = {r_quo[QW-2:0], div_ge};
        n_i0   = n_quo[QW-1:W_BITS];
        n_nxt  = (SIW+1)'(n_i0) + (SIW+1)'(1);
        ssz_x  = (SIW+1)'(r_ssz);
        n_i1   = (n_nxt >= ssz_x) ? SIW'(ssz_x - (SIW+1)'(1)) : n_nxt[SIW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_MUL;
                        r_cnt   <= CW'(SZW - 1);
                        r_coord <= i_coord;
                        r_msh   <= i_ssz;
                        r_ssz   <= i_ssz;
                        r_tsz   <= i_tsz;
                        r_prod  <= '0;
                    end
                end
                PH_MUL: begin
                    r_prod <= n_prod;
                    r_msh  <= {r_msh[SZW-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        // Upper product bits already lie below the target size
                        r_phase <= PH_DIV;
                        r_cnt   <= CW'(QW - 1);
                        r_rem   <= TZW'(n_prod >> SIW);
                        r_dsh   <= {n_prod[SIW-1:0], {W_BITS{1'b0}}};
                        r_quo   <= '0;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                PH_DIV: begin
                    r_rem <= n_rem;
                    r_dsh <= {r_dsh[QW-2:0], 1'b0};
                    r_quo <= n_quo;
                    if (r_cnt == '0) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                        r_i0    <= n_i0;
                        r_i1    <= n_i1;
                        r_frac  <= n_quo[W_BITS-1:0];
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = r_phase != PH_IDLE;
    assign o_stat.done = r_done;
    assign o_i0        = r_i0;
    assign o_i1        = r_i1;
    assign o_frac      = r_frac;

endmodule

// ----- rtl/cosine_interp_map_rescale.sv -----
// Write word: accepted while idle, no result; the next word may follow at once.
// Compute word: the result is registered after (log2(SOURCE_MAX)+1) serial multiply
// steps, (log2(SOURCE_MAX)+8) serial divide steps, then one weight lookup, the four
// source map corner reads and the blend passes.
// No new word is taken until a compute word is done; the result register frees the input side.
// Synchronous active-low reset clears control and size registers; map is not cleared.
module cosine_interp_map_rescale #(
    parameter int SOURCE_MAX = cimr_pkg::SOURCE_MAX_DEF,
    parameter int TARGET_MAX = cimr_pkg::TARGET_MAX_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cimr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [cimr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_command,
    input  logic [cimr_pkg::SRC_IDX_W-1:0]         i_source_col,
    input  logic [cimr_pkg::SRC_IDX_W-1:0]         i_source_row,
    input  logic signed [cimr_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic [cimr_pkg::COORD_W-1:0]           i_target_col,
    input  logic [cimr_pkg::COORD_W-1:0]           i_target_row,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [cimr_pkg::SAMPLE_W-1:0]   o_pixel_value,
    output logic [cimr_pkg::COORD_W-1:0]           o_pixel_col,
    output logic [cimr_pkg::COORD_W-1:0]           o_pixel_row
);
    import cimr_pkg::*;

    localparam int SZW    = $clog2(SOURCE_MAX + 1);
    localparam int TZW    = $clog2(TARGET_MAX + 1);
    localparam int SIW    = $clog2(SOURCE_MAX);
    localparam int DEPTH  = SOURCE_MAX * SOURCE_MAX;
    localparam int AW     = $clog2(DEPTH);
    localparam int DW     = SAMPLE_W + 1;
    localparam int PROD_W = 2 * DW;

    localparam t_wtab WTAB = build_wtab();

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_POS   = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_BLEND = 2'd3;

    logic [SRC_REG_W-1:0]        r_cfg_sw;
    logic [SRC_REG_W-1:0]        r_cfg_sh;
    logic [TGT_REG_W-1:0]        r_cfg_tw;
    logic [TGT_REG_W-1:0]        r_cfg_th;

    logic [1:0]                  r_state;
    logic [2:0]                  r_cnt;
    logic                        r_ovalid;
    logic [COORD_W-1:0]          r_pcol;
    logic [COORD_W-1:0]          r_prow;
    logic [COORD_W-1:0]          r_ocol;
    logic [COORD_W-1:0]          r_orow;
    logic signed [SAMPLE_W-1:0]  r_res;
    logic [WEIGHT_W-1:0]         r_wx;
    logic [WEIGHT_W-1:0]         r_wy;
    logic [SAMPLE_W-1:0]         r_map [DEPTH];
    logic [SAMPLE_W-1:0]         r_rdata;
    logic signed [SAMPLE_W-1:0]  r_smp [4];
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SAMPLE_W-1:0]  r_up;
    logic signed [SAMPLE_W-1:0]  r_lo;

    logic [SZW-1:0]              sz_x;
    logic [SZW-1:0]              sz_y;
    logic [TZW-1:0]              tz_x;
    logic [TZW-1:0]              tz_y;
    logic [COORD_W-1:0]          col_c;
    logic [COORD_W-1:0]          row_c;
    logic                        in_acc;
    logic                        start;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [SIW-1:0]              rd_row;
    logic [SIW-1:0]              rd_col;
    logic [AW-1:0]               rd_addr;
    t_axis_stat                  stat_x;
    t_axis_stat                  stat_y;
    logic [SIW-1:0]              x0;
    logic [SIW-1:0]              x1;
    logic [SIW-1:0]              y0;
    logic [SIW-1:0]              y1;
    logic [W_BITS-1:0]           frac_x;
    logic [W_BITS-1:0]           frac_y;
    logic signed [SAMPLE_W-1:0]  m_a;
    logic signed [SAMPLE_W-1:0]  m_b;
    logic [WEIGHT_W-1:0]         m_w;
    logic signed [DW-1:0]        m_d;
    logic signed [DW-1:0]        m_ws;
    logic signed [PROD_W-1:0]    n_prod;
    logic signed [SAMPLE_W-1:0]  b_base;
    logic signed [PROD_W-1:0]    rnd_sum;
    logic signed [PROD_W-1:0]    rnd_q;
    logic signed [PROD_W-1:0]    bl_sum;
    logic signed [SAMPLE_W-1:0]  blend;
    logic                        out_free;

    // Effective sizes: zero acts as one, oversize saturates; target coordinates clamp to the size
    always_comb begin
        if (r_cfg_sw == '0) sz_x = SZW'(1);
        else if (32'(r_cfg_sw) > 32'(SOURCE_MAX)) sz_x = SZW'(SOURCE_MAX);
        else sz_x = SZW'(r_cfg_sw);
        if (r_cfg_sh == '0) sz_y = SZW'(1);
        else if (32'(r_cfg_sh) > 32'(SOURCE_MAX)) sz_y = SZW'(SOURCE_MAX);
        else sz_y = SZW'(r_cfg_sh);
        if (r_cfg_tw == '0) tz_x = TZW'(1);
        else if (32'(r_cfg_tw) > 32'(TARGET_MAX)) tz_x = TZW'(TARGET_MAX);
        else tz_x = TZW'(r_cfg_tw);
        if (r_cfg_th == '0) tz_y = TZW'(1);
        else if (32'(r_cfg_th) > 32'(TARGET_MAX)) tz_y = TZW'(TARGET_MAX);
        else tz_y = TZW'(r_cfg_th);
        if (32'(i_target_col) >= 32'(tz_x)) col_c = COORD_W'(tz_x - TZW'(1));
        else col_c = i_target_col;
        if (32'(i_target_row) >= 32'(tz_y)) row_c = COORD_W'(tz_y - TZW'(1));
        else row_c = i_target_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw <= SRC_SIZE_RST;
            r_cfg_sh <= SRC_SIZE_RST;
            r_cfg_tw <= TGT_SIZE_RST;
            r_cfg_th <= TGT_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_cfg_sw <= i_cfg_data[SRC_REG_W-1:0];
                CFG_SRC_HEIGHT: r_cfg_sh <= i_cfg_data[SRC_REG_W-1:0];
                CFG_TGT_WIDTH:  r_cfg_tw <= i_cfg_data[TGT_REG_W-1:0];
                CFG_TGT_HEIGHT: r_cfg_th <= i_cfg_data[TGT_REG_W-1:0];
            endcase
        end
    end

    assign o_in_ready = r_state == ST_IDLE;
    assign in_acc     = i_in_valid && o_in_ready;
    assign start      = in_acc && (i_command == CMD_COMPUTE);
    assign wr_en      = in_acc && (i_command == CMD_WRITE)
                        && (32'(i_source_col) < 32'(SOURCE_MAX))
                        && (32'(i_source_row) < 32'(SOURCE_MAX));
    assign wr_addr    = AW'(32'(i_source_row) * 32'(SOURCE_MAX) + 32'(i_source_col));

    cimr_axis #(
        .SOURCE_MAX (SOURCE_MAX),
        .TARGET_MAX (TARGET_MAX)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_coord (col_c),
        .i_ssz   (sz_x),
        .i_tsz   (tz_x),
        .o_stat  (stat_x),
        .o_i0    (x0),
        .o_i1    (x1),
        .o_frac  (frac_x)
    );

    cimr_axis #(
        .SOURCE_MAX (SOURCE_MAX),
        .TARGET_MAX (TARGET_MAX)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_coord (row_c),
        .i_ssz   (sz_y),
        .i_tsz   (tz_y),
        .o_stat  (stat_y),
        .o_i0    (y0),
        .o_i1    (y1),
        .o_frac  (frac_y)
    );

    // Corner order: (y0,x0) (y0,x1) (y1,x0) (y1,x1)
    assign rd_en   = (r_state == ST_READ) && !r_cnt[2];
    assign rd_row  = r_cnt[1] ? y1 : y0;
    assign rd_col  = r_cnt[0] ? x1 : x0;
    assign rd_addr = AW'(32'(rd_row) * 32'(SOURCE_MAX) + 32'(rd_col));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= i_sample_value;
        end
        if (rd_en) begin
            r_rdata <= r_map[rd_addr];
        end
    end

    // Shared blend multiplier: two horizontal passes, then the vertical one
    always_comb begin
        case (r_cnt)
            3'd0: begin
                m_a = r_smp[0];
                m_b = r_smp[1];
                m_w = r_wx;
            end
            3'd1: begin
                m_a = r_smp[2];
                m_b = r_smp[3];
                m_w = r_wx;
            end
            default: begin
                m_a = r_up;
                m_b = r_lo;
                m_w = r_wy;
            end
        endcase
        case (r_cnt)
            3'd1:    b_base = r_smp[0];
            3'd2:    b_base = r_smp[2];
            default: b_base = r_up;
        endcase
        m_d     = DW'(m_b) - DW'(m_a);
        m_ws    = $signed({1'b0, m_w});
        n_prod  = m_d * m_ws;
        // Arithmetic shift floors, which rounds halves upward after the bias
        rnd_sum = r_prod + PROD_W'(ROUND_HALF);
        rnd_q   = rnd_sum >>> WQ_BITS;
        bl_sum  = PROD_W'(b_base) + rnd_q;
        blend   = bl_sum[SAMPLE_W-1:0];
    end

    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_POS;
                        r_pcol  <= col_c;
                        r_prow  <= row_c;
                    end
                end
                ST_POS: begin
                    if (stat_x.done) begin
                        r_wx    <= WTAB[frac_x];
                        r_wy    <= WTAB[frac_y];
                        r_state <= ST_READ;
                        r_cnt   <= '0;
                    end
                end
                ST_READ: begin
                    if (r_cnt != '0) begin
                        r_smp[2'(r_cnt - 3'd1)] <= r_rdata;
                    end
                    if (r_cnt == 3'd4) begin
                        r_state <= ST_BLEND;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                ST_BLEND: begin
                    case (r_cnt)
                        3'd0: r_prod <= n_prod;
                        3'd1: begin
                            r_up   <= blend;
                            r_prod <= n_prod;
                        end
                        3'd2: r_lo   <= blend;
                        3'd3: r_prod <= n_prod;
                        default: ;
                    endcase
                    if (r_cnt == 3'd4) begin
                        // Hold until the result register is free
                        if (out_free) begin
                            r_res    <= blend;
                            r_ocol   <= r_pcol;
                            r_orow   <= r_prow;
                            r_ovalid <= 1'b1;
                            r_state  <= ST_IDLE;
                            r_cnt    <= '0;
                        end
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_pixel_value = r_res;
    assign o_pixel_col   = r_ocol;
    assign o_pixel_row   = r_orow;

    a_axis_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat_x.done == stat_y.done)
        else $error("axis units out of step");

    a_pos_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POS) |-> (stat_x.busy || stat_x.done))
        else $error("waiting on an idle axis unit");

    a_rise_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_BLEND))
        else $error("result raised outside blend");

    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ((32'(r_ocol) < 32'(tz_x)) && (32'(r_orow) < 32'(tz_y))))
        else $error("result coordinate beyond target size");

endmodule

// ----- test/cosine_interp_map_rescale_tb.sv -----
`timescale 1ns / 100ps

module cosine_interp_map_rescale_tb;

    localparam int SRC_MAX = 32;
    localparam int TGT_MAX = 1024;
    localparam int WT_N = 256;
    localparam longint unsigned PI30 = 64'd3373259426;
    localparam longint unsigned UNIT30 = 64'd1073741824;

    typedef struct {
        logic                                 cmd;
        logic [cimr_pkg::SRC_IDX_W-1:0]       scol;
        logic [cimr_pkg::SRC_IDX_W-1:0]       srow;
        logic signed [cimr_pkg::SAMPLE_W-1:0] sval;
        logic [cimr_pkg::COORD_W-1:0]         tcol;
        logic [cimr_pkg::COORD_W-1:0]         trow;
    } map_word_t;

    typedef struct {
        logic signed [cimr_pkg::SAMPLE_W-1:0] value;
        logic [cimr_pkg::COORD_W-1:0]         col;
        logic [cimr_pkg::COORD_W-1:0]         row;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [cimr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [cimr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = 1'b0;
    logic [cimr_pkg::SRC_IDX_W-1:0] src_col = '0;
    logic [cimr_pkg::SRC_IDX_W-1:0] src_row = '0;
    logic signed [cimr_pkg::SAMPLE_W-1:0] sample = '0;
    logic [cimr_pkg::COORD_W-1:0] tgt_col = '0;
    logic [cimr_pkg::COORD_W-1:0] tgt_row = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [cimr_pkg::SAMPLE_W-1:0] pix_value;
    logic [cimr_pkg::COORD_W-1:0] pix_col;
    logic [cimr_pkg::COORD_W-1:0] pix_row;

    cosine_interp_map_rescale i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_command      (cmd),
        .i_source_col   (src_col),
        .i_source_row   (src_row),
        .i_sample_value (sample),
        .i_target_col   (tgt_col),
        .i_target_row   (tgt_row),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_value  (pix_value),
        .o_pixel_col    (pix_col),
        .o_pixel_row    (pix_row)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mirror of the block state
    logic signed [15:0] src_map [SRC_MAX*SRC_MAX];
    bit               loaded [SRC_MAX*SRC_MAX];
    logic [15:0]      cos_wt [WT_N];
    int unsigned      cfg_sw = 2, cfg_sh = 2, cfg_tw = 1024, cfg_th = 1024;

    map_word_t word_q [$];
    pixel_t    pending_pixels [$];
    int        err_cnt = 0;
    int        pixels_checked = 0;
    int        writes_sent = 0;
    int        settings_run = 0;

    function automatic longint cos_taylor(longint unsigned ang);
        longint unsigned sq;
        longint unsigned t;
        longint unsigned dv;
        longint          s;
        int              k;
        sq = (ang * ang) >> 30;
        t = UNIT30;
        s = longint'(UNIT30);
        for (k = 1; k <= 12; k++) begin
            dv = (2 * k - 1) * (2 * k);
            t = ((t * sq) >> 30) / dv;
            if (k % 2 == 1) begin
                s = s - longint'(t);
            end else begin
                s = s + longint'(t);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        if (s > longint'(UNIT30)) begin
            s = longint'(UNIT30);
        end
        return s;
    endfunction

    function automatic logic [15:0] cos_weight(int f);
        bit              flip;
        longint unsigned j;
        longint          h;
        flip = (2 * f) > WT_N;
        j = flip ? longint'(WT_N - f) : longint'(f);
        h = (longint'(UNIT30) - cos_taylor((PI30 * j) / WT_N) + 32768) >>> 16;
        if (flip) begin
            h = 32768 - h;
        end
        return h[15:0];
    endfunction

    function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    // One cosine step between a and b, halves rounded up
    function automatic longint mix(longint a, longint b, longint w);
        longint p;
        p = (b - a) * w + 16384;
        if (p >= 0) begin
            return a + (p >>> 15);
        end
        return a - ((-p + 32767) >>> 15);
    endfunction

    function automatic void axis_split(int unsigned coord, int unsigned ssz, int unsigned tsz,
                                       output int unsigned i0, output int unsigned i1,
                                       output longint w);
        longint unsigned p;
        longint unsigned q;
        longint unsigned rem;
        p = longint'(coord) * ssz;
        q = p / tsz;
        rem = p - q * tsz;
        i0 = q;
        i1 = (q + 1 >= ssz) ? ssz - 1 : q + 1;
        w = longint'(cos_wt[(rem * WT_N) / tsz]);
    endfunction

    function automatic longint map_at(int unsigned r, int unsigned c);
        return longint'(src_map[r * SRC_MAX + c]);
    endfunction

    function automatic pixel_t pixel_predict(map_word_t w);
        pixel_t      px;
        int unsigned sw, sh, tw, th, col, row, x0, x1, y0, y1;
        longint      wx, wy, up, lo, r;
        sw = eff_size(cfg_sw, SRC_MAX);
        sh = eff_size(cfg_sh, SRC_MAX);
        tw = eff_size(cfg_tw, TGT_MAX);
        th = eff_size(cfg_th, TGT_MAX);
        col = (w.tcol > tw - 1) ? tw - 1 : w.tcol;
        row = (w.trow > th - 1) ? th - 1 : w.trow;
        axis_split(col, sw, tw, x0, x1, wx);
        axis_split(row, sh, th, y0, y1, wy);
        up = mix(map_at(y0, x0), map_at(y0, x1), wx);
        lo = mix(map_at(y1, x0), map_at(y1, x1), wx);
        r = mix(up, lo, wy);
        px.value = r[15:0];
        px.col = col[9:0];
        px.row = row[9:0];
        return px;
    endfunction

    task automatic apply_word(map_word_t w);
        if (w.cmd == cimr_pkg::CMD_WRITE) begin
            src_map[w.srow * SRC_MAX + w.scol] = w.sval;
        end else begin
            pending_pixels.push_back(pixel_predict(w));
        end
    endtask

    // Driver: bursts of words with random gaps, occasional calm stretches
    int  burst_left = 1;
    int  gap_left = 0;
    int  drv_cycle = 0;
    bit  calm = 1'b0;
    map_word_t cur_word;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            drv_cycle++;
            if (drv_cycle % 256 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (in_valid && in_ready) begin
                apply_word(cur_word);
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    cur_word = word_q.pop_front();
                    cmd <= cur_word.cmd;
                    src_col <= cur_word.scol;
                    src_row <= cur_word.srow;
                    sample <= cur_word.sval;
                    tgt_col <= cur_word.tcol;
                    tgt_row <= cur_word.trow;
                    in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        if (calm || $urandom_range(0, 2) == 0) begin
                            gap_left = 0;
                        end else begin
                            gap_left = $urandom_range(1, 10);
                        end
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each pixel, stall on a rotating pattern, one long hold
    logic [15:0] pat = 16'hFFFF;
    int  mon_cycle = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk) begin
        pixel_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("unexpected pixel: value %0d col %0d row %0d",
                           pix_value, pix_col, pix_row);
                    err_cnt++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (pix_value !== want.value) begin
                        $error("pixel_value: expected %0d, got %0d", want.value, pix_value);
                        err_cnt++;
                    end
                    if (pix_col !== want.col) begin
                        $error("pixel_col: expected %0d, got %0d", want.col, pix_col);
                        err_cnt++;
                    end
                    if (pix_row !== want.row) begin
                        $error("pixel_row: expected %0d, got %0d", want.row, pix_row);
                        err_cnt++;
                    end
                end
                pixels_checked++;
            end
            mon_cycle++;
            if (mon_cycle % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: pat = 16'hFFFF;
                    1: pat = $urandom;
                    2: pat = $urandom | $urandom;
                    default: pat = ($urandom & $urandom) | 16'h0001;
                endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!hold_done && pixels_checked >= 120 && word_q.size() > 30) begin
                // starve the output so the block backs up into its input
                hold_done = 1'b1;
                hold_left = 400;
                out_ready <= 1'b0;
            end else begin
                out_ready <= pat[0];
                pat = {pat[0], pat[15:1]};
            end
        end
    end

    task automatic push_write(int c, int r, logic [15:0] v);
        map_word_t w;
        w.cmd = cimr_pkg::CMD_WRITE;
        w.scol = c;
        w.srow = r;
        w.sval = v;
        w.tcol = $urandom_range(0, 1023);
        w.trow = $urandom_range(0, 1023);
        loaded[r * SRC_MAX + c] = 1'b1;
        writes_sent++;
        word_q.push_back(w);
    endtask

    task automatic push_compute(int tc, int tr);
        map_word_t w;
        w.cmd = cimr_pkg::CMD_COMPUTE;
        w.scol = $urandom_range(0, 31);
        w.srow = $urandom_range(0, 31);
        w.sval = $urandom_range(0, 65535);
        w.tcol = tc;
        w.trow = tr;
        word_q.push_back(w);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int rand_coord(int unsigned tsz);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return tsz - 1;
            2, 3: return $urandom_range(0, 1023);
            default: return $urandom_range(0, tsz - 1);
        endcase
    endfunction

    task automatic cfg_write(logic [cimr_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cimr_pkg::CFG_SRC_WIDTH:  cfg_sw = v & 6'h3F;
            cimr_pkg::CFG_SRC_HEIGHT: cfg_sh = v & 6'h3F;
            cimr_pkg::CFG_TGT_WIDTH:  cfg_tw = v & 11'h7FF;
            default:                  cfg_th = v & 11'h7FF;
        endcase
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw,
                             int unsigned th);
        cfg_write(cimr_pkg::CFG_SRC_WIDTH, sw);
        cfg_write(cimr_pkg::CFG_SRC_HEIGHT, sh);
        cfg_write(cimr_pkg::CFG_TGT_WIDTH, tw);
        cfg_write(cimr_pkg::CFG_TGT_HEIGHT, th);
        settings_run++;
    endtask

    // Load every sample the current sizes can reach that was never written
    task automatic fill_region();
        int unsigned sw, sh;
        int          r, c;
        sw = eff_size(cfg_sw, SRC_MAX);
        sh = eff_size(cfg_sh, SRC_MAX);
        for (r = 0; r < sh; r++) begin
            for (c = 0; c < sw; c++) begin
                if (!loaded[r * SRC_MAX + c]) begin
                    push_write(c, r, rand_sample());
                end
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge clk);
        end while (word_q.size() != 0 || in_valid || pending_pixels.size() != 0);
        // the last word may be a write still in flight
        repeat (40) @(posedge clk);
    endtask

    initial begin
        int          p, n, f;
        int unsigned sw, sh, tw, th;
        for (f = 0; f < WT_N; f++) begin
            cos_wt[f] = cos_weight(f);
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: 2x2 source onto 1024x1024, extreme samples
        push_write(0, 0, 16'h8000);
        push_write(1, 0, 16'h7FFF);
        push_write(0, 1, 16'h7FFF);
        push_write(1, 1, 16'h8000);
        push_write(31, 31, 16'h5555);
        push_write(10, 21, 16'hAAAA);
        push_compute(0, 0);
        push_compute(1023, 1023);
        push_compute(511, 512);
        push_compute(512, 511);
        push_compute(1023, 0);
        push_compute(0, 1023);
        push_compute(1, 1);
        push_compute(768, 256);
        wait_drained();

        // zero sizes act as one: every coordinate clamps to zero
        set_sizes(0, 0, 0, 0);
        push_write(0, 0, 16'h1234);
        push_compute(0, 0);
        push_compute(1023, 1023);
        push_compute(5, 700);
        wait_drained();

        for (p = 0; p < 10; p++) begin
            case (p)
                0: set_sizes(32, 3, 1024, 700);
                1: set_sizes(3, 32, 5, 1024);
                2: set_sizes(63, 1, 2047, 1);
                3: set_sizes(1, 63, 1, 2047);
                default: begin
                    sw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) % 9
                                                     : $urandom_range(1, 8);
                    sh = $urandom_range(1, 8);
                    case ($urandom_range(0, 2))
                        0: tw = $urandom_range(1, 16);
                        1: tw = $urandom_range(1, 1024);
                        default: tw = $urandom_range(1025, 2047);
                    endcase
                    th = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                     : $urandom_range(1, 1024);
                    set_sizes(sw, sh, tw, th);
                end
            endcase
            fill_region();
            tw = eff_size(cfg_tw, TGT_MAX);
            th = eff_size(cfg_th, TGT_MAX);
            for (n = 0; n < 64; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_write($urandom_range(0, 31), $urandom_range(0, 31), rand_sample());
                end else begin
                    push_compute(rand_coord(tw), rand_coord(th));
                end
            end
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (pending_pixels.size() != 0) begin
            $error("%0d pixels never arrived", pending_pixels.size());
            err_cnt++;
        end
        $display("Covered %0d size settings, %0d sample writes and %0d checked pixels,",
                 settings_run, writes_sent, pixels_checked);
        $display("with sender gaps, receiver stalls and one long output hold.");
        if (err_cnt == 0) begin
            $display("cosine_interp_map_rescale_tb: PASS");
        end else begin
            $display("cosine_interp_map_rescale_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("cosine_interp_map_rescale_tb: FAIL");
        $finish;
    end

endmodule
